FILE: sv/first_fit_block_allocator_top_macros.svh
// assertion helpers used by the rtl core
`ifndef FIRST_FIT_BLOCK_ALLOCATOR_TOP_MACROS_SVH
`define FIRST_FIT_BLOCK_ALLOCATOR_TOP_MACROS_SVH

// same-cycle implication, disabled while in reset
`define FFBA_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while in reset
`define FFBA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/ffba_pkg.sv
`timescale 1ns / 1ps
package ffba_pkg;

    localparam int MAX_BLOCKS_DEF = 64;
    localparam int ADDR_BITS_DEF  = 32;
    localparam int SIZE_W         = 27;

    localparam logic [7:0]  HDR_RST        = 8'd32;
    localparam logic [15:0] MIN_SPLIT_RST  = 16'd128;
    localparam logic [26:0] LARGE_RST      = 27'd131072;
    localparam logic [26:0] MAX_REQ_RST    = 27'd100000000;
    localparam logic [31:0] HEAP_LIMIT_RST = 32'd16777216;

    typedef enum logic {
        OP_ALLOC = 1'b0,
        OP_FREE  = 1'b1
    } op_t;

    typedef enum logic [2:0] {
        STAT_OK        = 3'd0,
        STAT_BAD_SIZE  = 3'd1,
        STAT_LARGE     = 3'd2,
        STAT_HEAP_FULL = 3'd3,
        STAT_TBL_FULL  = 3'd4,
        STAT_IGNORED   = 3'd5
    } status_t;

    typedef enum logic [2:0] {
        REG_HEADER    = 3'd0,
        REG_MIN_SPLIT = 3'd1,
        REG_LARGE     = 3'd2,
        REG_MAX_REQ   = 3'd3,
        REG_LIMIT     = 3'd4
    } reg_idx_t;

    typedef struct packed {
        logic [7:0]        header_bytes;
        logic [15:0]       min_split_bytes;
        logic [SIZE_W-1:0] large_threshold;
        logic [SIZE_W-1:0] max_request;
        logic [31:0]       heap_limit;
    } cfg_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_START,
        S_SCAN_RD,
        S_SCAN_EX,
        S_INS_RD,
        S_INS_WR,
        S_SPLIT_HI,
        S_SPLIT_LO,
        S_NOHIT,
        S_NEXT_RD,
        S_NEXT_EX,
        S_REM_RD,
        S_REM_WR,
        S_PREV,
        S_FINISH
    } state_t;

endpackage

FILE: sv/first_fit_block_allocator_top.sv
`timescale 1ns / 1ps
// allocate: scans table entries in order, then shifts the tail up one entry on a split
// free: scans entries for the address, then moves the tail down one entry for each merge
// one request at a time: the block walks its table sequentially before taking the next
// the result register lets the next request start while a result waits
// reset: synchronous active-low aresetn clears counts, heap top and registers to defaults
module first_fit_block_allocator_top #(
    parameter int MAX_BLOCKS = ffba_pkg::MAX_BLOCKS_DEF,
    parameter int ADDR_BITS  = ffba_pkg::ADDR_BITS_DEF,
    parameter int CNT_W      = $clog2(MAX_BLOCKS + 1),
    parameter int IN_TW      = ((ffba_pkg::SIZE_W + ADDR_BITS + 7) / 8) * 8,
    parameter int OUT_TW     = ((3 + ADDR_BITS + 2 * CNT_W + 64 + 7) / 8) * 8
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [4:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    input  logic              s_tvalid,
    output logic              s_tready,
    // request_size, block_address
    input  logic [IN_TW-1:0]  s_tdata,
    // req_type
    input  logic              s_tuser,
    output logic              m_tvalid,
    input  logic              m_tready,
    // status, alloc_addr, block_total, free_block_total, used_byte_total, free_byte_total
    output logic [OUT_TW-1:0] m_tdata
);
    import ffba_pkg::*;

    cfg_t cfg_reg;
    status_t status;
    logic [ADDR_BITS-1:0] daddr;
    logic [CNT_W-1:0] blocks, fblocks;
    logic [31:0] used, fbytes;
    logic wr_en;

    // register writes
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.header_bytes    <= HDR_RST;
            cfg_reg.min_split_bytes <= MIN_SPLIT_RST;
            cfg_reg.large_threshold <= LARGE_RST;
            cfg_reg.max_request     <= MAX_REQ_RST;
            cfg_reg.heap_limit      <= HEAP_LIMIT_RST;
        end else if (wr_en) begin
            unique case (paddr[4:2])
                REG_HEADER:    cfg_reg.header_bytes    <= pwdata[7:0];
                REG_MIN_SPLIT: cfg_reg.min_split_bytes <= pwdata[15:0];
                REG_LARGE:     cfg_reg.large_threshold <= pwdata[SIZE_W-1:0];
                REG_MAX_REQ:   cfg_reg.max_request     <= pwdata[SIZE_W-1:0];
                REG_LIMIT:     cfg_reg.heap_limit      <= pwdata;
                default: ;
            endcase
        end
    end

    // register reads
    always_comb begin
        unique case (paddr[4:2])
            REG_HEADER:    prdata = 32'(cfg_reg.header_bytes);
            REG_MIN_SPLIT: prdata = 32'(cfg_reg.min_split_bytes);
            REG_LARGE:     prdata = 32'(cfg_reg.large_threshold);
            REG_MAX_REQ:   prdata = 32'(cfg_reg.max_request);
            REG_LIMIT:     prdata = cfg_reg.heap_limit;
            default:       prdata = '0;
        endcase
    end

    ffba_core #(
        .MAX_BLOCKS(MAX_BLOCKS),
        .ADDR_BITS (ADDR_BITS),
        .CNT_W     (CNT_W)
    ) u_core (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg            (cfg_reg),
        .in_valid       (s_tvalid),
        .in_ready       (s_tready),
        .in_op          (op_t'(s_tuser)),
        .in_size        (s_tdata[SIZE_W-1:0]),
        .in_addr        (s_tdata[SIZE_W +: ADDR_BITS]),
        .out_valid      (m_tvalid),
        .out_ready      (m_tready),
        .out_status     (status),
        .out_addr       (daddr),
        .out_blocks     (blocks),
        .out_free_blocks(fblocks),
        .out_used       (used),
        .out_free_bytes (fbytes)
    );

    // result packing, first field lowest
    assign m_tdata = OUT_TW'({fbytes, used, fblocks, blocks, daddr, status});

endmodule

FILE: sv/ffba_core.sv
`timescale 1ns / 1ps
`include "first_fit_block_allocator_top_macros.svh"
module ffba_core #(
    parameter int MAX_BLOCKS = 64,
    parameter int ADDR_BITS  = 32,
    parameter int CNT_W      = $clog2(MAX_BLOCKS + 1)
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  ffba_pkg::cfg_t              cfg,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  ffba_pkg::op_t               in_op,
    input  logic [ffba_pkg::SIZE_W-1:0] in_size,
    input  logic [ADDR_BITS-1:0]        in_addr,
    output logic                        out_valid,
    input  logic                        out_ready,
    output ffba_pkg::status_t           out_status,
    output logic [ADDR_BITS-1:0]        out_addr,
    output logic [CNT_W-1:0]            out_blocks,
    output logic [CNT_W-1:0]            out_free_blocks,
    output logic [31:0]                 out_used,
    output logic [31:0]                 out_free_bytes
);
    import ffba_pkg::*;

    localparam int IDX_W = $clog2(MAX_BLOCKS);
    localparam int BW    = ((ADDR_BITS > 32) ? ADDR_BITS : 32) + 1;

    typedef struct packed {
        logic [ADDR_BITS-1:0] start;
        logic [SIZE_W-1:0]    size;
        logic                 free;
    } entry_t;

    // block table
    entry_t mem [MAX_BLOCKS];
    entry_t rd_q;
    logic             mem_we;
    logic [IDX_W-1:0] mem_waddr, mem_raddr;
    entry_t           mem_wdata;

    state_t state_reg, state_next;
    op_t op_reg;
    logic [SIZE_W-1:0] req_reg;
    logic [ADDR_BITS-1:0] baddr_reg;
    logic [CNT_W-1:0] idx_reg, idx_next, k_reg, k_next, hit_reg, hit_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next, fcnt_reg, fcnt_next;
    logic [ADDR_BITS-1:0] fstart_reg, fstart_next, top_reg, top_next;
    logic [ADDR_BITS-1:0] addr_reg, addr_next;
    logic [SIZE_W-1:0] fsize_reg, fsize_next;
    entry_t prev_reg, prev_next;
    logic [31:0] bsum_reg, bsum_next, fbsum_reg, fbsum_next;
    status_t st_reg, st_next;
    logic rem_last_reg, rem_last_next;
    logic out_valid_reg;
    status_t o_status_reg;
    logic [ADDR_BITS-1:0] o_addr_reg;
    logic [CNT_W-1:0] o_blocks_reg, o_fblocks_reg;
    logic [31:0] o_used_reg, o_fbytes_reg;

    // shared conditions
    logic size_bad, size_large, fit, split_ok, match, last_free, out_load;
    logic grow_over, app_over, next_merge_ok, prev_merge_ok;
    logic [CNT_W-1:0] hp1, km1, kp1;
    logic [SIZE_W-1:0] diff, left;
    logic [SIZE_W:0] m_next_sz, m_prev_sz;
    logic [SIZE_W+1:0] split_need;
    logic [BW-1:0] bound, hl_ext, amax, grow_nt, app_nt;

    assign size_bad   = (req_reg == '0) || (req_reg > cfg.max_request);
    assign size_large = req_reg >= cfg.large_threshold;
    assign fit        = rd_q.free && (rd_q.size >= req_reg);
    assign split_need = (SIZE_W+2)'(req_reg) + (SIZE_W+2)'(cfg.min_split_bytes)
                        + (SIZE_W+2)'(cfg.header_bytes);
    assign split_ok   = (cnt_reg < CNT_W'(MAX_BLOCKS)) && ((SIZE_W+2)'(rd_q.size) >= split_need);
    assign match      = rd_q.start == baddr_reg;
    assign last_free  = (cnt_reg != '0) && prev_reg.free;
    assign hp1        = hit_reg + 1'b1;
    assign km1        = k_reg - 1'b1;
    assign kp1        = k_reg + 1'b1;
    assign diff       = req_reg - prev_reg.size;
    assign left       = fsize_reg - req_reg - SIZE_W'(cfg.header_bytes);
    assign m_next_sz  = (SIZE_W+1)'(fsize_reg) + (SIZE_W+1)'(cfg.header_bytes)
                        + (SIZE_W+1)'(rd_q.size);
    assign m_prev_sz  = (SIZE_W+1)'(prev_reg.size) + (SIZE_W+1)'(cfg.header_bytes)
                        + (SIZE_W+1)'(fsize_reg);
    assign next_merge_ok = rd_q.free && !m_next_sz[SIZE_W];
    assign prev_merge_ok = (hit_reg != '0) && prev_reg.free && !m_prev_sz[SIZE_W];

    // heap top bound is the smaller of the limit register and the address range
    assign hl_ext    = BW'(cfg.heap_limit);
    assign amax      = BW'({ADDR_BITS{1'b1}});
    assign bound     = (hl_ext < amax) ? hl_ext : amax;
    assign grow_nt   = BW'(top_reg) + BW'(diff);
    assign app_nt    = BW'(top_reg) + BW'(cfg.header_bytes) + BW'(req_reg);
    assign grow_over = grow_nt > bound;
    assign app_over  = app_nt > bound;
    assign out_load  = !out_valid_reg || out_ready;

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:     if (in_valid) state_next = S_START;
            S_START: begin
                if (op_reg == OP_ALLOC && (size_bad || size_large)) state_next = S_FINISH;
                else state_next = S_SCAN_RD;
            end
            S_SCAN_RD: begin
                if (idx_reg != cnt_reg) state_next = S_SCAN_EX;
                else if (op_reg == OP_ALLOC) state_next = S_NOHIT;
                else state_next = S_FINISH;
            end
            S_SCAN_EX: begin
                if (op_reg == OP_ALLOC) begin
                    if (fit) state_next = split_ok ? S_INS_RD : S_FINISH;
                    else state_next = S_SCAN_RD;
                end else begin
                    if (match) state_next = rd_q.free ? S_FINISH : S_NEXT_RD;
                    else state_next = S_SCAN_RD;
                end
            end
            S_INS_RD:   state_next = (k_reg > hp1) ? S_INS_WR : S_SPLIT_HI;
            S_INS_WR:   state_next = S_INS_RD;
            S_SPLIT_HI: state_next = S_SPLIT_LO;
            S_SPLIT_LO: state_next = S_FINISH;
            S_NOHIT:    state_next = S_FINISH;
            S_NEXT_RD:  state_next = (hp1 < cnt_reg) ? S_NEXT_EX : S_PREV;
            S_NEXT_EX:  state_next = next_merge_ok ? S_REM_RD : S_PREV;
            S_REM_RD: begin
                if (kp1 < cnt_reg) state_next = S_REM_WR;
                else state_next = rem_last_reg ? S_FINISH : S_PREV;
            end
            S_REM_WR:   state_next = S_REM_RD;
            S_PREV:     state_next = prev_merge_ok ? S_REM_RD : S_FINISH;
            S_FINISH:   if (out_load) state_next = S_IDLE;
            default:    state_next = S_IDLE;
        endcase
    end

    // datapath and table control
    always_comb begin
        idx_next = idx_reg;  k_next = k_reg;  hit_next = hit_reg;
        cnt_next = cnt_reg;  fcnt_next = fcnt_reg;
        fstart_next = fstart_reg;  fsize_next = fsize_reg;  top_next = top_reg;
        addr_next = addr_reg;  prev_next = prev_reg;
        bsum_next = bsum_reg;  fbsum_next = fbsum_reg;
        st_next = st_reg;  rem_last_next = rem_last_reg;
        mem_we = 1'b0;  mem_waddr = '0;  mem_wdata = '0;  mem_raddr = '0;
        unique case (state_reg)
            S_START: begin
                idx_next  = '0;
                addr_next = '0;
                prev_next = '0;
                st_next   = (op_reg == OP_ALLOC) ? STAT_OK : STAT_IGNORED;
                if (op_reg == OP_ALLOC && size_bad) st_next = STAT_BAD_SIZE;
                else if (op_reg == OP_ALLOC && size_large) st_next = STAT_LARGE;
            end
            S_SCAN_RD: mem_raddr = idx_reg[IDX_W-1:0];
            S_SCAN_EX: begin
                if (op_reg == OP_ALLOC && fit) begin
                    hit_next    = idx_reg;
                    fstart_next = rd_q.start;
                    fsize_next  = rd_q.size;
                    fbsum_next  = fbsum_reg - 32'(rd_q.size);
                    if (split_ok) begin
                        k_next = cnt_reg;
                    end else begin
                        fcnt_next = fcnt_reg - 1'b1;
                        mem_we    = 1'b1;
                        mem_waddr = idx_reg[IDX_W-1:0];
                        mem_wdata = '{start: rd_q.start, size: rd_q.size, free: 1'b0};
                        addr_next = rd_q.start;
                        st_next   = STAT_OK;
                    end
                end else if (op_reg == OP_FREE && match) begin
                    if (!rd_q.free) begin
                        hit_next    = idx_reg;
                        fstart_next = rd_q.start;
                        fsize_next  = rd_q.size;
                        fcnt_next   = fcnt_reg + 1'b1;
                        fbsum_next  = fbsum_reg + 32'(rd_q.size);
                        mem_we      = 1'b1;
                        mem_waddr   = idx_reg[IDX_W-1:0];
                        mem_wdata   = '{start: rd_q.start, size: rd_q.size, free: 1'b1};
                        st_next     = STAT_OK;
                    end
                end else begin
                    prev_next = rd_q;
                    idx_next  = idx_reg + 1'b1;
                end
            end
            // open a slot after the hit by moving the tail up one entry
            S_INS_RD: mem_raddr = km1[IDX_W-1:0];
            S_INS_WR: begin
                mem_we    = 1'b1;
                mem_waddr = k_reg[IDX_W-1:0];
                mem_wdata = rd_q;
                k_next    = km1;
            end
            S_SPLIT_HI: begin
                mem_we     = 1'b1;
                mem_waddr  = hp1[IDX_W-1:0];
                mem_wdata  = '{start: fstart_reg + ADDR_BITS'(req_reg)
                                      + ADDR_BITS'(cfg.header_bytes),
                               size: left, free: 1'b1};
                cnt_next   = cnt_reg + 1'b1;
                fbsum_next = fbsum_reg + 32'(left);
                bsum_next  = bsum_reg - 32'(cfg.header_bytes);
            end
            S_SPLIT_LO: begin
                mem_we    = 1'b1;
                mem_waddr = hit_reg[IDX_W-1:0];
                mem_wdata = '{start: fstart_reg, size: req_reg, free: 1'b0};
                addr_next = fstart_reg;
                st_next   = STAT_OK;
            end
            // nothing fits: grow a free last block or append at the top, else report heap or table full
            S_NOHIT: begin
                if (last_free) begin
                    if (grow_over) begin
                        st_next = STAT_HEAP_FULL;
                    end else begin
                        top_next   = grow_nt[ADDR_BITS-1:0];
                        fbsum_next = fbsum_reg - 32'(prev_reg.size);
                        fcnt_next  = fcnt_reg - 1'b1;
                        bsum_next  = bsum_reg + 32'(diff);
                        mem_we     = 1'b1;
                        mem_waddr  = IDX_W'(cnt_reg - 1'b1);
                        mem_wdata  = '{start: prev_reg.start, size: req_reg, free: 1'b0};
                        addr_next  = prev_reg.start;
                    end
                end else if (cnt_reg >= CNT_W'(MAX_BLOCKS)) begin
                    st_next = STAT_TBL_FULL;
                end else if (app_over) begin
                    st_next = STAT_HEAP_FULL;
                end else begin
                    mem_we    = 1'b1;
                    mem_waddr = cnt_reg[IDX_W-1:0];
                    mem_wdata = '{start: top_reg + ADDR_BITS'(cfg.header_bytes),
                                  size: req_reg, free: 1'b0};
                    addr_next = top_reg + ADDR_BITS'(cfg.header_bytes);
                    cnt_next  = cnt_reg + 1'b1;
                    top_next  = app_nt[ADDR_BITS-1:0];
                    bsum_next = bsum_reg + 32'(req_reg);
                end
            end
            S_NEXT_RD: mem_raddr = hp1[IDX_W-1:0];
            S_NEXT_EX: begin
                if (next_merge_ok) begin
                    fsize_next    = m_next_sz[SIZE_W-1:0];
                    mem_we        = 1'b1;
                    mem_waddr     = hit_reg[IDX_W-1:0];
                    mem_wdata     = '{start: fstart_reg, size: m_next_sz[SIZE_W-1:0],
                                      free: 1'b1};
                    fcnt_next     = fcnt_reg - 1'b1;
                    bsum_next     = bsum_reg + 32'(cfg.header_bytes);
                    fbsum_next    = fbsum_reg + 32'(cfg.header_bytes);
                    k_next        = hp1;
                    rem_last_next = 1'b0;
                end
            end
            // close a slot by moving the tail down one entry
            S_REM_RD: begin
                mem_raddr = kp1[IDX_W-1:0];
                if (!(kp1 < cnt_reg)) cnt_next = cnt_reg - 1'b1;
            end
            S_REM_WR: begin
                mem_we    = 1'b1;
                mem_waddr = k_reg[IDX_W-1:0];
                mem_wdata = rd_q;
                k_next    = kp1;
            end
            S_PREV: begin
                if (prev_merge_ok) begin
                    mem_we        = 1'b1;
                    mem_waddr     = IDX_W'(hit_reg - 1'b1);
                    mem_wdata     = '{start: prev_reg.start, size: m_prev_sz[SIZE_W-1:0],
                                      free: 1'b1};
                    fcnt_next     = fcnt_reg - 1'b1;
                    bsum_next     = bsum_reg + 32'(cfg.header_bytes);
                    fbsum_next    = fbsum_reg + 32'(cfg.header_bytes);
                    k_next        = hit_reg;
                    rem_last_next = 1'b1;
                end
            end
            default: ;
        endcase
    end

    // table storage
    always_ff @(posedge aclk) begin
        if (mem_we) mem[mem_waddr] <= mem_wdata;
        rd_q <= mem[mem_raddr];
    end

    // control and count registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            fcnt_reg      <= '0;
            top_reg       <= '0;
            bsum_reg      <= '0;
            fbsum_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            fcnt_reg  <= fcnt_next;
            top_reg   <= top_next;
            bsum_reg  <= bsum_next;
            fbsum_reg <= fbsum_next;
            if (state_reg == S_FINISH && out_load) out_valid_reg <= 1'b1;
            else if (out_ready) out_valid_reg <= 1'b0;
        end
    end

    // working and result payload registers
    always_ff @(posedge aclk) begin
        if (state_reg == S_IDLE && in_valid) begin
            op_reg    <= in_op;
            req_reg   <= in_size;
            baddr_reg <= in_addr;
        end
        idx_reg      <= idx_next;
        k_reg        <= k_next;
        hit_reg      <= hit_next;
        fstart_reg   <= fstart_next;
        fsize_reg    <= fsize_next;
        addr_reg     <= addr_next;
        prev_reg     <= prev_next;
        st_reg       <= st_next;
        rem_last_reg <= rem_last_next;
        if (state_reg == S_FINISH && out_load) begin
            o_status_reg  <= st_reg;
            o_addr_reg    <= (st_reg == STAT_OK) ? addr_reg : '0;
            o_blocks_reg  <= cnt_reg;
            o_fblocks_reg <= fcnt_reg;
            o_used_reg    <= bsum_reg;
            o_fbytes_reg  <= fbsum_reg;
        end
    end

    assign in_ready        = state_reg == S_IDLE;
    assign out_valid       = out_valid_reg;
    assign out_status      = o_status_reg;
    assign out_addr        = o_addr_reg;
    assign out_blocks      = o_blocks_reg;
    assign out_free_blocks = o_fblocks_reg;
    assign out_used        = o_used_reg;
    assign out_free_bytes  = o_fbytes_reg;

    `FFBA_ASSERT_NOW(a_free_le_blocks, 1'b1, fcnt_reg <= cnt_reg, "free count above block count")
    `FFBA_ASSERT_NOW(a_blocks_bound, 1'b1, cnt_reg <= CNT_W'(MAX_BLOCKS), "block count overflow")
    `FFBA_ASSERT_NOW(a_err_addr_zero, out_valid_reg && o_status_reg != STAT_OK, o_addr_reg == '0, "nonzero address on error")
    `FFBA_ASSERT_NEXT(a_busy_after_req, in_valid && in_ready, !in_ready, "ready held after a request")

endmodule

FILE: tb/sv/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
    import ffba_pkg::*;

    localparam int BLOCKS = 64;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int SETTLE_CYCLES = 600;

    typedef struct packed {
        logic              op;
        logic [SIZE_W-1:0] size;
        logic [31:0]       addr;
    } alloc_req_t;

    // packed from the top down, so the first result field sits lowest
    typedef struct packed {
        logic [31:0] free_bytes;
        logic [31:0] used_bytes;
        logic [6:0]  free_block_total;
        logic [6:0]  block_total;
        logic [31:0] alloc_addr;
        logic [2:0]  status;
    } alloc_resp_t;

    logic          aclk = 1'b0;
    logic          aresetn = 1'b0;
    logic          psel = 1'b0;
    logic          penable = 1'b0;
    logic          pwrite = 1'b0;
    logic [4:0]    paddr = '0;
    logic [31:0]   pwdata = '0;
    logic [31:0]   prdata;
    logic          pready;
    logic          s_tvalid = 1'b0;
    logic          s_tready;
    logic [63:0]   s_tdata = '0;
    logic          s_tuser = 1'b0;
    logic          m_tvalid;
    logic          m_tready = 1'b0;
    logic [119:0]  m_tdata;

    first_fit_block_allocator_top dut (
        .aclk(aclk), .aresetn(aresetn),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    // clock
    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // shadow of the block table and registers
    logic [7:0]        hdr_bytes;
    logic [15:0]       split_min;
    logic [SIZE_W-1:0] large_min;
    logic [SIZE_W-1:0] size_max;
    logic [31:0]       top_limit;
    longint unsigned   blk_start [BLOCKS];
    logic [SIZE_W-1:0] blk_size [BLOCKS];
    logic              blk_free [BLOCKS];
    int                blk_count;
    int                free_count;
    logic [31:0]       heap_top;
    logic [31:0]       used_sum;
    logic [31:0]       free_sum;

    alloc_req_t  pending_reqs [$];
    alloc_resp_t expected_resps [$];
    int          errors = 0;
    int          status_seen [6];
    int          req_accepted = 0;
    int          resp_checked = 0;
    int          idle_cycles = 0;
    bit          calm = 0;
    bit          hold_off = 0;

    // run one request through the shadow table
    function automatic alloc_resp_t heap_step(alloc_req_t r);
        alloc_resp_t     e;
        int              hit;
        int              l;
        longint unsigned nt;
        logic [31:0]     diff;
        logic [SIZE_W-1:0] s;
        logic [SIZE_W-1:0] left;
        longint unsigned m;
        e = '0;
        e.status = STAT_OK;
        if (r.op == OP_ALLOC) begin
            if (r.size == 0 || r.size > size_max) e.status = STAT_BAD_SIZE;
            else if (r.size >= large_min) e.status = STAT_LARGE;
            else begin
                hit = -1;
                for (int i = 0; i < blk_count; i++)
                    if (hit < 0 && blk_free[i] && blk_size[i] >= r.size) hit = i;
                if (hit >= 0) begin
                    s = blk_size[hit];
                    free_sum = free_sum - s;
                    if (blk_count < BLOCKS && longint'(s) >=
                        longint'(r.size) + longint'(split_min) + longint'(hdr_bytes)) begin
                        left = s - r.size - hdr_bytes;
                        for (int k = blk_count; k > hit + 1; k--) begin
                            blk_start[k] = blk_start[k-1];
                            blk_size[k] = blk_size[k-1];
                            blk_free[k] = blk_free[k-1];
                        end
                        blk_count++;
                        blk_start[hit+1] = blk_start[hit] + r.size + hdr_bytes;
                        blk_size[hit+1] = left;
                        blk_free[hit+1] = 1'b1;
                        blk_size[hit] = r.size;
                        free_sum = free_sum + left;
                        used_sum = used_sum - hdr_bytes;
                    end else free_count--;
                    blk_free[hit] = 1'b0;
                    e.alloc_addr = blk_start[hit][31:0];
                end else if (blk_count > 0 && blk_free[blk_count-1]) begin
                    l = blk_count - 1;
                    diff = 32'(r.size) - 32'(blk_size[l]);
                    nt = longint'(heap_top) + diff;
                    if (nt > top_limit) e.status = STAT_HEAP_FULL;
                    else begin
                        heap_top = nt[31:0];
                        free_sum = free_sum - blk_size[l];
                        free_count--;
                        used_sum = used_sum + diff;
                        blk_size[l] = r.size;
                        blk_free[l] = 1'b0;
                        e.alloc_addr = blk_start[l][31:0];
                    end
                end else if (blk_count >= BLOCKS) e.status = STAT_TBL_FULL;
                else begin
                    nt = longint'(heap_top) + hdr_bytes + r.size;
                    if (nt > top_limit) e.status = STAT_HEAP_FULL;
                    else begin
                        blk_start[blk_count] = longint'(heap_top) + hdr_bytes;
                        blk_size[blk_count] = r.size;
                        blk_free[blk_count] = 1'b0;
                        e.alloc_addr = blk_start[blk_count][31:0];
                        blk_count++;
                        heap_top = nt[31:0];
                        used_sum = used_sum + r.size;
                    end
                end
            end
        end else begin
            hit = -1;
            for (int i = 0; i < blk_count; i++)
                if (hit < 0 && blk_start[i] == longint'(r.addr)) hit = i;
            if (hit < 0 || blk_free[hit]) e.status = STAT_IGNORED;
            else begin
                blk_free[hit] = 1'b1;
                free_count++;
                free_sum = free_sum + blk_size[hit];
                // merge with free next neighbor, unless it overflows the size field
                if (hit + 1 < blk_count && blk_free[hit+1]) begin
                    m = longint'(blk_size[hit]) + hdr_bytes + blk_size[hit+1];
                    if (m <= 64'h7FFFFFF) begin
                        blk_size[hit] = m[SIZE_W-1:0];
                        for (int k = hit + 1; k + 1 < blk_count; k++) begin
                            blk_start[k] = blk_start[k+1];
                            blk_size[k] = blk_size[k+1];
                            blk_free[k] = blk_free[k+1];
                        end
                        blk_count--;
                        free_count--;
                        used_sum = used_sum + hdr_bytes;
                        free_sum = free_sum + hdr_bytes;
                    end
                end
                // merge into free previous neighbor
                if (hit > 0 && blk_free[hit-1]) begin
                    m = longint'(blk_size[hit-1]) + hdr_bytes + blk_size[hit];
                    if (m <= 64'h7FFFFFF) begin
                        blk_size[hit-1] = m[SIZE_W-1:0];
                        for (int k = hit; k + 1 < blk_count; k++) begin
                            blk_start[k] = blk_start[k+1];
                            blk_size[k] = blk_size[k+1];
                            blk_free[k] = blk_free[k+1];
                        end
                        blk_count--;
                        free_count--;
                        used_sum = used_sum + hdr_bytes;
                        free_sum = free_sum + hdr_bytes;
                    end
                end
            end
        end
        if (e.status != STAT_OK) e.alloc_addr = '0;
        e.block_total = 7'(blk_count);
        e.free_block_total = 7'(free_count);
        e.used_bytes = used_sum;
        e.free_bytes = free_sum;
        return e;
    endfunction

    // queue a request with its predicted response
    task automatic queue_request(op_t op, logic [SIZE_W-1:0] size, logic [31:0] addr);
        alloc_req_t r;
        r.op = op;
        r.size = size;
        r.addr = addr;
        pending_reqs.push_back(r);
        expected_resps.push_back(heap_step(r));
    endtask

    task automatic write_reg(reg_idx_t idx, logic [31:0] v);
        @(negedge aclk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= v;
        @(negedge aclk);
        penable <= 1'b1;
        @(negedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_HEADER:    hdr_bytes = v[7:0];
            REG_MIN_SPLIT: split_min = v[15:0];
            REG_LARGE:     large_min = v[SIZE_W-1:0];
            REG_MAX_REQ:   size_max = v[SIZE_W-1:0];
            REG_LIMIT:     top_limit = v;
            default: ;
        endcase
    endtask

    task automatic set_config(logic [7:0] h, logic [15:0] sp, logic [26:0] lg,
                              logic [26:0] mx, logic [31:0] lim);
        write_reg(REG_HEADER, 32'(h));
        write_reg(REG_MIN_SPLIT, 32'(sp));
        write_reg(REG_LARGE, 32'(lg));
        write_reg(REG_MAX_REQ, 32'(mx));
        write_reg(REG_LIMIT, lim);
    endtask

    // wait for every queued request to come back, then let the block go quiet
    task automatic drain;
        while (pending_reqs.size() != 0 || expected_resps.size() != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    // random requests: mostly small allocates and frees of live blocks
    task automatic random_requests(int n);
        int pick;
        int live [$];
        for (int j = 0; j < n; j++) begin
            pick = $urandom_range(0, 99);
            if (pick < 50) begin
                if ($urandom_range(0, 9) == 0)
                    queue_request(OP_ALLOC, 27'($urandom()), 32'($urandom()));
                else if ($urandom_range(0, 19) == 0)
                    queue_request(OP_ALLOC, large_min - 27'($urandom_range(0, 1)),
                                  32'($urandom()));
                else
                    queue_request(OP_ALLOC, 27'($urandom_range(1, 600)), 32'($urandom()));
            end else begin
                live.delete();
                for (int i = 0; i < blk_count; i++)
                    if (!blk_free[i] || $urandom_range(0, 9) == 0) live.push_back(i);
                if (live.size() != 0 && pick < 92)
                    queue_request(OP_FREE, 27'($urandom()),
                                  blk_start[live[$urandom_range(0, live.size() - 1)]][31:0]);
                else
                    queue_request(OP_FREE, 27'($urandom()), 32'($urandom()));
            end
        end
    endtask

    // request driver
    bit s_took = 0;
    int gap = 0;
    always @(negedge aclk) begin
        logic       nv;
        alloc_req_t r;
        if (aresetn) begin
            nv = s_tvalid && !s_took;
            if (!nv) begin
                if (gap > 0) gap--;
                else if (pending_reqs.size() != 0) begin
                    r = pending_reqs.pop_front();
                    s_tdata <= {5'b0, r.addr, r.size};
                    s_tuser <= r.op;
                    nv = 1'b1;
                    if (!calm && $urandom_range(0, 7) == 0) gap = $urandom_range(1, 6);
                end
            end
            s_tvalid <= nv;
        end
    end

    // response ready with random stalls and one long hold
    int rstall = 0;
    always @(negedge aclk) begin
        logic rdy;
        if (aresetn) begin
            if (rstall > 0) begin
                rstall--;
                rdy = 1'b0;
            end else if (!calm && $urandom_range(0, 9) == 0) begin
                rstall = $urandom_range(0, 5);
                rdy = 1'b0;
            end else rdy = 1'b1;
            m_tready <= rdy && !hold_off;
        end
    end

    initial begin
        wait (req_accepted >= 300);
        @(negedge aclk);
        hold_off = 1;
        repeat (400) @(negedge aclk);
        hold_off = 0;
    end

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        errors++;
        $display("mismatch on response %0d: %s got %0d expected %0d",
                 resp_checked, what, got, want);
    endtask

    // response monitor and watchdog
    always @(posedge aclk) begin
        alloc_resp_t g;
        alloc_resp_t e;
        s_took <= s_tvalid && s_tready;
        if (s_tvalid && s_tready) req_accepted++;
        if (m_tvalid && m_tready) begin
            g = m_tdata[112:0];
            if (expected_resps.size() == 0) begin
                report_mismatch("response with no request outstanding", 32'd1, 32'd0);
            end else begin
                e = expected_resps.pop_front();
                if (g.status != e.status) report_mismatch("status", 32'(g.status), 32'(e.status));
                if (g.alloc_addr != e.alloc_addr)
                    report_mismatch("alloc_addr", g.alloc_addr, e.alloc_addr);
                if (g.block_total != e.block_total)
                    report_mismatch("block_total", 32'(g.block_total), 32'(e.block_total));
                if (g.free_block_total != e.free_block_total)
                    report_mismatch("free_block_total", 32'(g.free_block_total),
                                    32'(e.free_block_total));
                if (g.used_bytes != e.used_bytes)
                    report_mismatch("used_byte_total", g.used_bytes, e.used_bytes);
                if (g.free_bytes != e.free_bytes)
                    report_mismatch("free_byte_total", g.free_bytes, e.free_bytes);
                if (e.status <= STAT_IGNORED) status_seen[e.status]++;
            end
            resp_checked++;
        end
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
        else if (aresetn) idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WATCHDOG_LIMIT) begin
            $display("tb_top: FAIL");
            $finish;
        end
    end

    // stimulus
    initial begin
        hdr_bytes = HDR_RST;
        split_min = MIN_SPLIT_RST;
        large_min = LARGE_RST;
        size_max = MAX_REQ_RST;
        top_limit = HEAP_LIMIT_RST;
        blk_count = 0;
        free_count = 0;
        heap_top = '0;
        used_sum = '0;
        free_sum = '0;
        repeat (9) @(negedge aclk);
        aresetn <= 1'b1;

        // size checks, unknown and double frees, a split, then random requests
        queue_request(OP_ALLOC, 27'd0, 32'hFFFF_FFFF);
        queue_request(OP_ALLOC, 27'd100000001, 32'd0);
        queue_request(OP_ALLOC, 27'h7FF_FFFF, 32'd0);
        queue_request(OP_ALLOC, 27'd131072, 32'd0);
        queue_request(OP_ALLOC, 27'd131071, 32'd0);
        queue_request(OP_FREE, 27'h7FF_FFFF, 32'hFFFF_FFFF);
        queue_request(OP_FREE, 27'd0, 32'd0);
        queue_request(OP_ALLOC, 27'd100, 32'd0);
        queue_request(OP_ALLOC, 27'd300, 32'd0);
        queue_request(OP_ALLOC, 27'd50, 32'd0);
        queue_request(OP_FREE, 27'd0, 32'd131103 + 32'd132);
        queue_request(OP_ALLOC, 27'd40, 32'd0);
        queue_request(OP_FREE, 27'd0, 32'd32);
        queue_request(OP_FREE, 27'd0, 32'd32);
        queue_request(OP_FREE, 27'd0, 32'd131103 + 32'd464);
        queue_request(OP_ALLOC, 27'd1, 32'd0);
        queue_request(OP_ALLOC, 27'd5000, 32'd0);
        random_requests(180);
        drain();

        // wide-open limits: oversized merge skipped, then table fill
        set_config(8'd1, 16'd0, 27'h7FF_FFFF, 27'h7FF_FFFF, 32'hFFFF_FFFF);
        queue_request(OP_ALLOC, 27'd100000000, 32'd0);
        queue_request(OP_ALLOC, 27'd100000000, 32'd0);
        for (int i = 0; i < blk_count; i++)
            if (blk_size[i] == 27'd100000000)
                queue_request(OP_FREE, 27'd0, blk_start[i][31:0]);
        for (int i = 0; i < 70; i++) queue_request(OP_ALLOC, 27'd1, 32'd0);
        random_requests(130);
        drain();

        // every allocate refused, zero heap limit
        set_config(8'd255, 16'd65535, 27'd1, 27'd1, 32'd0);
        queue_request(OP_ALLOC, 27'd1, 32'd0);
        queue_request(OP_ALLOC, 27'd2, 32'd0);
        random_requests(30);
        drain();

        // tight heap limit: heap full is common
        set_config(8'd16, 16'd64, 27'd4096, 27'd3000, heap_top + 32'd20000);
        random_requests(250);
        drain();

        // back to defaults; the tail runs without idling
        set_config(HDR_RST, MIN_SPLIT_RST, LARGE_RST, MAX_REQ_RST, HEAP_LIMIT_RST);
        random_requests(120);
        while (pending_reqs.size() > 20) @(negedge aclk);
        calm = 1;
        random_requests(150);
        drain();

        $display("requests checked: %0d; ok %0d, bad size %0d, large %0d", resp_checked,
                 status_seen[0], status_seen[1], status_seen[2]);
        $display("heap full %0d, table full %0d, ignored frees %0d, mismatches %0d",
                 status_seen[3], status_seen[4], status_seen[5], errors);
        if (errors == 0) $display("tb_top: PASS");
        else $display("tb_top: FAIL");
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+sv
sv/ffba_pkg.sv
sv/ffba_core.sv
sv/first_fit_block_allocator_top.sv
tb/sv/tb_top.sv
